FILE: hdl/tcc_pkg.sv
package tcc_pkg;

   localparam int AREA_BITS = 12;
   localparam int PAD_BITS = 10;
   localparam int CELLW_BITS = 7;
   localparam int CELLH_BITS = 8;
   localparam int CSR_ADDR_BITS = 3;
   localparam int CSR_DATA_BITS = 12;
   localparam int CHAR_BITS = 8;
   localparam int POS_BITS = 12;
   localparam int DIV_STEPS = AREA_BITS;

   localparam logic [CSR_ADDR_BITS-1:0] REG_AREA_WIDTH = 3'd0;
   localparam logic [CSR_ADDR_BITS-1:0] REG_AREA_HEIGHT = 3'd1;
   localparam logic [CSR_ADDR_BITS-1:0] REG_PAD_LEFT = 3'd2;
   localparam logic [CSR_ADDR_BITS-1:0] REG_PAD_TOP = 3'd3;
   localparam logic [CSR_ADDR_BITS-1:0] REG_CELL_WIDTH = 3'd4;
   localparam logic [CSR_ADDR_BITS-1:0] REG_CELL_HEIGHT = 3'd5;

   localparam logic [CHAR_BITS-1:0] CHAR_BS = 8'd8;
   localparam logic [CHAR_BITS-1:0] CHAR_TAB = 8'd9;
   localparam logic [CHAR_BITS-1:0] CHAR_LF = 8'd10;
   localparam logic [CHAR_BITS-1:0] CHAR_CR = 8'd13;

   localparam logic CMD_DRAW = 1'b0;
   localparam logic CMD_SCROLL = 1'b1;

   typedef enum logic [3:0] {
      OP_NONE,
      OP_LOAD,
      OP_ACT,
      OP_DRAW,
      OP_DIV,
      OP_MUL,
      OP_BS,
      OP_POST,
      OP_DRAIN
   } dp_op_type;

   typedef struct packed {
      dp_op_type op;
   } dp_cmd_type;

   typedef struct packed {
      logic printable;
      logic bs_wrap;
      logic div_last;
      logic drain_end;
   } dp_status_type;

endpackage

FILE: hdl/tcc_ctrl.sv
module tcc_ctrl
   import tcc_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   output logic          req_tready,
   output dp_cmd_type    cmd,
   input  dp_status_type status
);

   typedef enum logic [7:0] {
      S_IDLE  = 8'b0000_0001,
      S_ACT   = 8'b0000_0010,
      S_DRAW  = 8'b0000_0100,
      S_DIV   = 8'b0000_1000,
      S_MUL   = 8'b0001_0000,
      S_BS    = 8'b0010_0000,
      S_POST  = 8'b0100_0000,
      S_DRAIN = 8'b1000_0000
   } state_type;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_tready = (state_ff == S_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd.op = OP_NONE;
      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               cmd.op = OP_LOAD;
               state_in = S_ACT;
            end
         end
         S_ACT: begin
            cmd.op = OP_ACT;
            if (status.printable) begin
               state_in = S_DRAW;
            end else if (status.bs_wrap) begin
               state_in = S_DIV;
            end else begin
               state_in = S_POST;
            end
         end
         S_DRAW: begin
            cmd.op = OP_DRAW;
            state_in = S_POST;
         end
         S_DIV: begin
            cmd.op = OP_DIV;
            if (status.div_last) begin
               state_in = S_MUL;
            end
         end
         S_MUL: begin
            cmd.op = OP_MUL;
            state_in = S_BS;
         end
         S_BS: begin
            cmd.op = OP_BS;
            state_in = S_POST;
         end
         S_POST: begin
            cmd.op = OP_POST;
            state_in = S_DRAIN;
         end
         S_DRAIN: begin
            cmd.op = OP_DRAIN;
            if (status.drain_end) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

endmodule

FILE: hdl/tcc_datapath.sv
module tcc_datapath
   import tcc_pkg::*;
#(
   parameter int COORD_BITS = 12,
   parameter int TAB_CELLS = 4
)
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     csr_we,
   input  logic [CSR_ADDR_BITS-1:0] csr_addr,
   input  logic [CSR_DATA_BITS-1:0] csr_wdata,
   input  logic [CHAR_BITS-1:0]     req_tdata,
   input  dp_cmd_type               cmd,
   output dp_status_type            status,
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   output logic [31:0]              rsp_tdata,
   output logic                     rsp_tuser,
   output logic                     rsp_tlast
);

   localparam int CW = COORD_BITS;
   localparam int AW = COORD_BITS + 12;
   localparam logic [AW-1:0] CMAX = AW'((64'd1 << CW) - 64'd1);
   localparam int PROD_BITS = AREA_BITS + CELLW_BITS;

   typedef struct packed {
      logic                cmd;
      logic [CHAR_BITS-1:0] glyph;
      logic [POS_BITS-1:0] x;
      logic [POS_BITS-1:0] y;
   } item_type;

   function automatic logic [CW-1:0] sat(input logic [AW-1:0] v);
      logic [AW-1:0] r;
      r = (v > CMAX) ? CMAX : v;
      return r[CW-1:0];
   endfunction

   function automatic logic [POS_BITS-1:0] to_pos(input logic [CW-1:0] v);
      logic [CW+POS_BITS-1:0] e;
      e = {{POS_BITS{1'b0}}, v};
      return e[POS_BITS-1:0];
   endfunction

   // configuration
   logic [AREA_BITS-1:0]  area_w_ff, area_h_ff;
   logic [PAD_BITS-1:0]   pad_l_ff, pad_t_ff;
   logic [CELLW_BITS-1:0] cell_w_ff;
   logic [CELLH_BITS-1:0] cell_h_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         area_w_ff <= 12'd640;
         area_h_ff <= 12'd480;
         pad_l_ff <= '0;
         pad_t_ff <= '0;
         cell_w_ff <= 7'd8;
         cell_h_ff <= 8'd16;
      end else if (csr_we) begin
         unique case (csr_addr)
            REG_AREA_WIDTH:  area_w_ff <= csr_wdata[AREA_BITS-1:0];
            REG_AREA_HEIGHT: area_h_ff <= csr_wdata[AREA_BITS-1:0];
            REG_PAD_LEFT:    pad_l_ff <= csr_wdata[PAD_BITS-1:0];
            REG_PAD_TOP:     pad_t_ff <= csr_wdata[PAD_BITS-1:0];
            REG_CELL_WIDTH:  cell_w_ff <= csr_wdata[CELLW_BITS-1:0];
            REG_CELL_HEIGHT: cell_h_ff <= csr_wdata[CELLH_BITS-1:0];
            default: ;
         endcase
      end
   end

   // effective geometry
   logic [CELLW_BITS-1:0] fw7;
   logic [AW-1:0] fw, fh, px, py, aw_x, ah_x, mw, mh, span;

   always_comb begin
      fw7 = (cell_w_ff == '0) ? CELLW_BITS'(1) : cell_w_ff;
      fw = AW'(fw7);
      fh = (cell_h_ff == '0) ? AW'(1) : AW'(cell_h_ff);
      px = AW'(pad_l_ff);
      py = AW'(pad_t_ff);
      aw_x = AW'(area_w_ff);
      ah_x = AW'(area_h_ff);
      mw = (aw_x > px) ? aw_x - px : '0;
      mh = (ah_x > py) ? ah_x - py : '0;
      span = (mw > px) ? mw - px : '0;
   end

   // state
   logic [CHAR_BITS-1:0] char_ff, char_in;
   logic [CW-1:0] col_ff, col_in, row_ff, row_in;
   logic [AREA_BITS-1:0] quo_ff, quo_in;
   logic [CELLW_BITS-1:0] rem_ff, rem_in;
   logic [3:0] dcnt_ff, dcnt_in;
   logic [PROD_BITS-1:0] prod_ff, prod_in;
   item_type buf_ff [3];
   item_type push_item;
   logic push_en;
   logic [1:0] cnt_ff, cnt_in, rd_ff, rd_in;
   logic rsp_valid_ff, rsp_valid_in, rsp_last_ff, rsp_last_in;
   item_type rsp_item_ff, rsp_item_in;

   // wrap then scroll check on the current cursor
   logic [AW-1:0] colx, rowx, col_w, row_w, row_s, tab_step, tab_x;
   logic wrap_hit, scroll_hit, bs_back, bs_up, push_ok;
   logic [CELLW_BITS:0] trial;
   logic trial_ge;

   always_comb begin
      colx = AW'(col_ff);
      rowx = AW'(row_ff);
      wrap_hit = (colx + fw) > mw;
      col_w = wrap_hit ? AW'(sat(px)) : colx;
      row_w = wrap_hit ? AW'(sat(rowx + fh)) : rowx;
      scroll_hit = (row_w + fh) > mh;
      row_s = scroll_hit ? ((row_w >= fh) ? row_w - fh : '0) : row_w;
      tab_step = fw * AW'(TAB_CELLS);
      tab_x = (colx + tab_step) & ~(tab_step - AW'(1));
      if (tab_x < px) begin
         tab_x = px;
      end
      bs_back = colx >= (px + fw);
      bs_up = rowx >= (py + fh);
      trial = {rem_ff, quo_ff[AREA_BITS-1]};
      trial_ge = trial >= {1'b0, fw7};
      push_ok = !rsp_valid_ff || rsp_tready;
   end

   always_comb begin
      status.printable = 1'b1;
      unique case (char_ff) inside
         CHAR_LF, CHAR_CR, CHAR_BS, CHAR_TAB: status.printable = 1'b0;
         default: status.printable = 1'b1;
      endcase
      status.bs_wrap = (char_ff == CHAR_BS) && !bs_back && bs_up;
      status.div_last = (dcnt_ff == 4'(DIV_STEPS - 1));
      status.drain_end = (rd_ff == cnt_ff) || (push_ok && ((rd_ff + 2'd1) == cnt_ff));
   end

   always_comb begin
      char_in = char_ff;
      col_in = col_ff;
      row_in = row_ff;
      quo_in = quo_ff;
      rem_in = rem_ff;
      dcnt_in = dcnt_ff;
      prod_in = prod_ff;
      cnt_in = cnt_ff;
      rd_in = rd_ff;
      push_en = 1'b0;
      push_item = '{cmd: CMD_SCROLL, glyph: '0, x: to_pos(col_w[CW-1:0]),
                    y: to_pos(row_s[CW-1:0])};
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_last_in = rsp_last_ff;
      rsp_item_in = rsp_item_ff;

      case (cmd.op)
         OP_LOAD: begin
            char_in = req_tdata;
            cnt_in = '0;
            rd_in = '0;
         end
         OP_ACT: begin
            unique case (char_ff)
               CHAR_LF: begin
                  col_in = sat(px);
                  row_in = sat(rowx + fh);
               end
               CHAR_CR: begin
                  col_in = sat(px);
               end
               CHAR_BS: begin
                  if (bs_back) begin
                     col_in = col_ff - fw[CW-1:0];
                  end else if (bs_up) begin
                     quo_in = span[AREA_BITS-1:0];
                     rem_in = '0;
                     dcnt_in = '0;
                  end
               end
               CHAR_TAB: begin
                  col_in = sat(tab_x);
               end
               default: begin
                  // pre-draw wrap and scroll
                  col_in = col_w[CW-1:0];
                  row_in = row_s[CW-1:0];
                  push_en = scroll_hit;
               end
            endcase
         end
         OP_DRAW: begin
            push_en = 1'b1;
            push_item = '{cmd: CMD_DRAW, glyph: char_ff, x: to_pos(col_ff),
                          y: to_pos(row_ff)};
            col_in = sat(colx + fw);
         end
         OP_DIV: begin
            // restoring divide, one quotient bit per cycle
            rem_in = trial_ge ? CELLW_BITS'(trial - {1'b0, fw7}) : trial[CELLW_BITS-1:0];
            quo_in = {quo_ff[AREA_BITS-2:0], trial_ge};
            dcnt_in = dcnt_ff + 4'd1;
         end
         OP_MUL: begin
            prod_in = PROD_BITS'(quo_ff - AREA_BITS'(1)) * PROD_BITS'(fw7);
         end
         OP_BS: begin
            row_in = CW'(rowx - fh);
            col_in = (quo_ff != '0) ? sat(px + AW'(prod_ff)) : sat(px);
         end
         OP_POST: begin
            col_in = col_w[CW-1:0];
            row_in = row_s[CW-1:0];
            push_en = scroll_hit;
         end
         OP_DRAIN: begin
            if ((rd_ff != cnt_ff) && push_ok) begin
               rsp_valid_in = 1'b1;
               rsp_item_in = buf_ff[rd_ff];
               rsp_last_in = (rd_ff + 2'd1) == cnt_ff;
               rd_in = rd_ff + 2'd1;
            end
         end
         default: ;
      endcase

      if (push_en) begin
         cnt_in = cnt_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
         cnt_ff <= '0;
         rd_ff <= '0;
         dcnt_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         col_ff <= col_in;
         row_ff <= row_in;
         cnt_ff <= cnt_in;
         rd_ff <= rd_in;
         dcnt_ff <= dcnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      char_ff <= char_in;
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      prod_ff <= prod_in;
      rsp_item_ff <= rsp_item_in;
      rsp_last_ff <= rsp_last_in;
      if (push_en) begin
         buf_ff[cnt_ff] <= push_item;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser = rsp_item_ff.cmd;
   assign rsp_tlast = rsp_last_ff;
   assign rsp_tdata = {rsp_item_ff.y, rsp_item_ff.x, rsp_item_ff.glyph};

endmodule

FILE: hdl/text_console_cursor_control.sv
// Text console cursor controller. Each character transfer on req_ moves a pixel cursor inside
// the padded drawing area set by the csr_ registers and produces zero to three commands on
// rsp_ (scroll before a draw, the draw, scroll after), the final one marked by tlast.
// Newline, return, tab and plain backspace can cause one scroll. A backspace that wraps to
// the line above runs a one-bit-per-cycle divider over the usable line width. Commands are
// delivered through one output register, so a stalled sink holds the block in its delivery
// step. The cursor does not move on register writes; the user must write the registers only
// while the block is idle, which the block itself does not enforce.
module text_console_cursor_control
   import tcc_pkg::*;
#(
   parameter int COORD_BITS = 12,
   parameter int TAB_CELLS = 4
)
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     csr_we,
   input  logic [CSR_ADDR_BITS-1:0] csr_addr,
   input  logic [CSR_DATA_BITS-1:0] csr_wdata,
   input  logic                     req_tvalid,
   output logic                     req_tready,
   input  logic [7:0]               req_tdata,   // char_code[7:0]
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   output logic [31:0]              rsp_tdata,   // glyph[7:0], pos_x[19:8], pos_y[31:20]
   output logic                     rsp_tuser,   // command: 0 draw, 1 scroll
   output logic                     rsp_tlast
);

   dp_cmd_type    cmd;
   dp_status_type status;

   tcc_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .cmd        (cmd),
      .status     (status)
   );

   tcc_datapath #(
      .COORD_BITS (COORD_BITS),
      .TAB_CELLS  (TAB_CELLS)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata),
      .req_tdata  (req_tdata),
      .cmd        (cmd),
      .status     (status),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

FILE: tb/tb.sv
module tb;
   timeunit 1ns;
   timeprecision 1ps;
   import tcc_pkg::*;

   localparam int unsigned COORD_MAX = 4095;
   localparam int unsigned TAB_STOPS = 4;
   // a wrapping backspace keeps the block busy with nothing to show for it
   localparam int SETTLE_CYCLES = 24;
   localparam int PHASES = 8;
   localparam int PHASE_CHARS = 60;

   typedef struct packed {
      logic       cmd;
      logic [7:0] glyph;
      logic [11:0] x;
      logic [11:0] y;
      logic       last;
   } cmd_type;

   typedef enum logic {ROW_CHAR, ROW_REG} row_kind_type;

   typedef struct packed {
      row_kind_type             kind;
      logic [CSR_ADDR_BITS-1:0] idx;
      logic [11:0]              value;
      logic                     fixed;      // outcome written out in the row
      logic                     fixed_draw; // fixed row yields a single draw at fx, fy
      logic [11:0]              fx;
      logic [11:0]              fy;
   } dir_row_type;

   localparam int DIR_ROWS = 41;
   localparam dir_row_type DIR_TABLE [0:DIR_ROWS-1] = '{
      // reset setup: 640 x 480, no pad, 8 x 16 cells
      '{ROW_CHAR, '0, 12'd0,           1'b1, 1'b1, 12'd0,   12'd0},
      '{ROW_CHAR, '0, 12'd255,         1'b1, 1'b1, 12'd8,   12'd0},
      '{ROW_CHAR, '0, {4'd0, CHAR_CR}, 1'b1, 1'b0, 12'd0,   12'd0},
      '{ROW_CHAR, '0, {4'd0, CHAR_BS}, 1'b1, 1'b0, 12'd0,   12'd0},
      '{ROW_CHAR, '0, {4'd0, CHAR_TAB}, 1'b1, 1'b0, 12'd0,  12'd0},
      '{ROW_CHAR, '0, 12'd65,          1'b1, 1'b1, 12'd32,  12'd0},
      '{ROW_CHAR, '0, {4'd0, CHAR_LF}, 1'b1, 1'b0, 12'd0,   12'd0},
      '{ROW_CHAR, '0, {4'd0, CHAR_BS}, 1'b1, 1'b0, 12'd0,   12'd0},
      '{ROW_CHAR, '0, 12'd122,         1'b1, 1'b1, 12'd632, 12'd0},
      '{ROW_CHAR, '0, {4'd0, CHAR_BS}, 1'b0, 1'b0, 12'd0,   12'd0},
      // short area: scroll after the draw, scroll on newline
      '{ROW_REG,  REG_AREA_HEIGHT, 12'd20, 1'b0, 1'b0, 12'd0, 12'd0},
      '{ROW_CHAR, '0, 12'd66,          1'b0, 1'b0, 12'd0,   12'd0},
      '{ROW_CHAR, '0, {4'd0, CHAR_LF}, 1'b0, 1'b0, 12'd0,   12'd0},
      // area lower than a cell: scroll above top, three commands
      '{ROW_REG,  REG_AREA_HEIGHT, 12'd10, 1'b0, 1'b0, 12'd0, 12'd0},
      '{ROW_CHAR, '0, 12'd67,          1'b0, 1'b0, 12'd0,   12'd0},
      // zero cell size
      '{ROW_REG,  REG_CELL_WIDTH, 12'd0,   1'b0, 1'b0, 12'd0, 12'd0},
      '{ROW_REG,  REG_CELL_HEIGHT, 12'd0,  1'b0, 1'b0, 12'd0, 12'd0},
      '{ROW_CHAR, '0, 12'd68,          1'b0, 1'b0, 12'd0,   12'd0},
      '{ROW_CHAR, '0, {4'd0, CHAR_TAB}, 1'b0, 1'b0, 12'd0,  12'd0},
      '{ROW_CHAR, '0, {4'd0, CHAR_BS}, 1'b0, 1'b0, 12'd0,   12'd0},
      // line narrower than a cell: backspace wrap lands on the pad
      '{ROW_REG,  REG_AREA_WIDTH, 12'd20,  1'b0, 1'b0, 12'd0, 12'd0},
      '{ROW_REG,  REG_PAD_LEFT, 12'd8,     1'b0, 1'b0, 12'd0, 12'd0},
      '{ROW_REG,  REG_AREA_HEIGHT, 12'd4095, 1'b0, 1'b0, 12'd0, 12'd0},
      '{ROW_REG,  REG_CELL_WIDTH, 12'd8,   1'b0, 1'b0, 12'd0, 12'd0},
      '{ROW_REG,  REG_CELL_HEIGHT, 12'd16, 1'b0, 1'b0, 12'd0, 12'd0},
      '{ROW_CHAR, '0, {4'd0, CHAR_LF}, 1'b0, 1'b0, 12'd0,   12'd0},
      '{ROW_CHAR, '0, {4'd0, CHAR_BS}, 1'b0, 1'b0, 12'd0,   12'd0},
      '{ROW_CHAR, '0, 12'd69,          1'b0, 1'b0, 12'd0,   12'd0},
      // left pad larger than the area width
      '{ROW_REG,  REG_PAD_LEFT, 12'd1023,  1'b0, 1'b0, 12'd0, 12'd0},
      '{ROW_REG,  REG_PAD_TOP, 12'd1023,   1'b0, 1'b0, 12'd0, 12'd0},
      '{ROW_CHAR, '0, 12'd70,          1'b0, 1'b0, 12'd0,   12'd0},
      '{ROW_CHAR, '0, {4'd0, CHAR_TAB}, 1'b0, 1'b0, 12'd0,  12'd0},
      // widest setup: backspace wrap to column 3968, then tab runs past the coordinate range
      '{ROW_REG,  REG_AREA_WIDTH, 12'd4095, 1'b0, 1'b0, 12'd0, 12'd0},
      '{ROW_REG,  REG_PAD_LEFT, 12'd0,     1'b0, 1'b0, 12'd0, 12'd0},
      '{ROW_REG,  REG_PAD_TOP, 12'd0,      1'b0, 1'b0, 12'd0, 12'd0},
      '{ROW_REG,  REG_CELL_WIDTH, 12'd64,  1'b0, 1'b0, 12'd0, 12'd0},
      '{ROW_REG,  REG_CELL_HEIGHT, 12'd128, 1'b0, 1'b0, 12'd0, 12'd0},
      '{ROW_CHAR, '0, {4'd0, CHAR_LF}, 1'b0, 1'b0, 12'd0,   12'd0},
      '{ROW_CHAR, '0, {4'd0, CHAR_BS}, 1'b0, 1'b0, 12'd0,   12'd0},
      '{ROW_CHAR, '0, {4'd0, CHAR_TAB}, 1'b0, 1'b0, 12'd0,  12'd0},
      '{ROW_CHAR, '0, 12'd71,          1'b0, 1'b0, 12'd0,   12'd0}
   };

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     csr_we = 1'b0;
   logic [CSR_ADDR_BITS-1:0] csr_addr = '0;
   logic [CSR_DATA_BITS-1:0] csr_wdata = '0;
   logic                     req_tvalid = 1'b0;
   logic                     req_tready;
   logic [7:0]               req_tdata = '0;
   logic                     rsp_tvalid;
   logic                     rsp_tready = 1'b0;
   logic [31:0]              rsp_tdata;
   logic                     rsp_tuser;
   logic                     rsp_tlast;

   text_console_cursor_control dut (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // cursor and register copies, at their reset values
   int unsigned area_w = 640, area_h = 480, pad_l = 0, pad_t = 0, cell_w = 8, cell_h = 16;
   int unsigned cur_x = 0, cur_y = 0;

   cmd_type     step_cmds[$];
   cmd_type     due_cmds[$];
   cmd_type     head_cmd;
   int          mismatches = 0;
   bit          sent_since_idle = 1'b0;
   int unsigned cycle_no = 0;

   always @(posedge clock) cycle_no <= cycle_no + 1;

   task automatic flag_mismatch(input string what, input int got, input int want);
      $display("%0t mismatch in %s: got %0d, want %0d", $realtime, what, got, want);
      mismatches++;
   endtask

   function automatic int unsigned sat_coord(input int unsigned v);
      return v > COORD_MAX ? COORD_MAX : v;
   endfunction

   function automatic void push_cmd(input logic cmd, input logic [7:0] glyph);
      cmd_type c;
      c.cmd = cmd;
      c.glyph = glyph;
      c.x = cur_x[11:0];
      c.y = cur_y[11:0];
      c.last = 1'b0;
      step_cmds.push_back(c);
   endfunction

   function automatic void line_wrap(input int unsigned fw, input int unsigned fh,
                                     input int unsigned mw);
      if (cur_x + fw > mw) begin
         cur_x = sat_coord(pad_l);
         cur_y = sat_coord(cur_y + fh);
      end
   endfunction

   function automatic void bottom_scroll(input int unsigned fh, input int unsigned mh);
      if (cur_y + fh > mh) begin
         cur_y = cur_y >= fh ? cur_y - fh : 0;
         push_cmd(CMD_SCROLL, 8'd0);
      end
   endfunction

   // moves the cursor for one character and leaves the commands it causes in step_cmds
   function automatic void advance_cursor(input logic [7:0] code);
      int unsigned fw, fh, mw, mh, span, cells, tab_step, x;
      cmd_type tail;
      step_cmds.delete();
      fw = cell_w != 0 ? cell_w : 1;
      fh = cell_h != 0 ? cell_h : 1;
      mw = area_w > pad_l ? area_w - pad_l : 0;
      mh = area_h > pad_t ? area_h - pad_t : 0;
      case (code)
         CHAR_LF: begin
            cur_x = sat_coord(pad_l);
            cur_y = sat_coord(cur_y + fh);
         end
         CHAR_CR: cur_x = sat_coord(pad_l);
         CHAR_BS: begin
            if (cur_x >= pad_l + fw) begin
               cur_x = cur_x - fw;
            end else if (cur_y >= pad_t + fh) begin
               span = mw > pad_l ? mw - pad_l : 0;
               cells = span / fw;
               cur_y = cur_y - fh;
               cur_x = sat_coord(cells != 0 ? pad_l + (cells - 1) * fw : pad_l);
            end
         end
         CHAR_TAB: begin
            tab_step = fw * TAB_STOPS;
            x = (cur_x + tab_step) & ~(tab_step - 1);
            if (x < pad_l) x = pad_l;
            cur_x = sat_coord(x);
         end
         default: begin
            line_wrap(fw, fh, mw);
            bottom_scroll(fh, mh);
            push_cmd(CMD_DRAW, code);
            cur_x = sat_coord(cur_x + fw);
         end
      endcase
      line_wrap(fw, fh, mw);
      bottom_scroll(fh, mh);
      if (step_cmds.size() != 0) begin
         tail = step_cmds.pop_back();
         tail.last = 1'b1;
         step_cmds.push_back(tail);
      end
   endfunction

   // stretches with no gaps on either side, between stretches of random gaps
   function automatic int pick_gap();
      int r;
      if ((cycle_no / 2500) % 3 == 0) return 0;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   function automatic logic [7:0] pick_char();
      int r;
      r = $urandom_range(0, 99);
      if (r < 12) return CHAR_LF;
      if (r < 18) return CHAR_CR;
      if (r < 28) return CHAR_BS;
      if (r < 36) return CHAR_TAB;
      return 8'($urandom_range(0, 255));
   endfunction

   task automatic write_reg(input logic [CSR_ADDR_BITS-1:0] idx, input int unsigned val);
      if (sent_since_idle) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
         while (due_cmds.size() != 0) @(posedge clock);
         repeat (SETTLE_CYCLES) @(posedge clock);
         sent_since_idle = 1'b0;
      end
      csr_addr <= idx;
      csr_wdata <= val[CSR_DATA_BITS-1:0];
      csr_we <= 1'b1;
      @(posedge clock);
      csr_we <= 1'b0;
      case (idx)
         REG_AREA_WIDTH:  area_w = val[AREA_BITS-1:0];
         REG_AREA_HEIGHT: area_h = val[AREA_BITS-1:0];
         REG_PAD_LEFT:    pad_l = val[PAD_BITS-1:0];
         REG_PAD_TOP:     pad_t = val[PAD_BITS-1:0];
         REG_CELL_WIDTH:  cell_w = val[CELLW_BITS-1:0];
         REG_CELL_HEIGHT: cell_h = val[CELLH_BITS-1:0];
         default: ;
      endcase
      @(posedge clock);
   endtask

   task automatic send_char(input logic [7:0] code, input logic fixed, input logic fixed_draw,
                            input logic [11:0] fx, input logic [11:0] fy);
      req_tdata <= code;
      req_tvalid <= 1'b1;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      advance_cursor(code);
      sent_since_idle = 1'b1;
      if (fixed) begin
         if (fixed_draw) due_cmds.push_back('{CMD_DRAW, code, fx, fy, 1'b1});
      end else begin
         foreach (step_cmds[i]) due_cmds.push_back(step_cmds[i]);
      end
   endtask

   task automatic idle_after_send(input bit drain);
      int hold;
      hold = pick_gap();
      if (hold > 0 || drain) begin
         req_tvalid <= 1'b0;
         repeat (hold) @(posedge clock);
         if (drain) begin
            @(posedge clock);
            while (due_cmds.size() != 0) @(posedge clock);
         end
      end
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (due_cmds.size() == 0) begin
            flag_mismatch("command with none due", rsp_tdata, 0);
         end else begin
            head_cmd = due_cmds.pop_front();
            if (rsp_tuser !== head_cmd.cmd) flag_mismatch("command", rsp_tuser, head_cmd.cmd);
            if (rsp_tdata[7:0] !== head_cmd.glyph)
               flag_mismatch("glyph", rsp_tdata[7:0], head_cmd.glyph);
            if (rsp_tdata[19:8] !== head_cmd.x) flag_mismatch("pos_x", rsp_tdata[19:8], head_cmd.x);
            if (rsp_tdata[31:20] !== head_cmd.y)
               flag_mismatch("pos_y", rsp_tdata[31:20], head_cmd.y);
            if (rsp_tlast !== head_cmd.last) flag_mismatch("last", rsp_tlast, head_cmd.last);
         end
      end
   end

   // sink side: ready drops for a while after some transfers
   initial begin : sink
      int hold;
      forever begin
         rsp_tready <= 1'b1;
         @(posedge clock);
         while (!(rsp_tvalid && rsp_tready)) @(posedge clock);
         hold = pick_gap();
         if (hold > 0) begin
            rsp_tready <= 1'b0;
            repeat (hold) @(posedge clock);
         end
      end
   end

   initial begin : stimulus
      int k, ph, spin;
      dir_row_type row;
      int unsigned aw, ah, pl, pt, cw, ch;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (k = 0; k < DIR_ROWS; k++) begin
         row = DIR_TABLE[k];
         if (row.kind == ROW_REG) begin
            write_reg(row.idx, row.value);
         end else begin
            send_char(row.value[7:0], row.fixed, row.fixed_draw, row.fx, row.fy);
            idle_after_send(1'b0);
         end
      end

      for (ph = 0; ph < PHASES; ph++) begin
         case (ph)
            0: begin
               aw = 640; ah = 480; pl = 0; pt = 0; cw = 8; ch = 16;
            end
            1: begin
               aw = 4095; ah = 4095; pl = 1023; pt = 1023; cw = 64; ch = 128;
            end
            2: begin
               aw = 1; ah = 1; pl = 0; pt = 0; cw = 1; ch = 1;
            end
            default: begin
               aw = $urandom_range(0, 1) ? $urandom_range(64, 1024) : $urandom_range(1, 4095);
               ah = $urandom_range(0, 1) ? $urandom_range(64, 1024) : $urandom_range(1, 4095);
               pl = $urandom_range(0, 3) != 0 ? $urandom_range(0, 40) : $urandom_range(0, 1023);
               pt = $urandom_range(0, 3) != 0 ? $urandom_range(0, 40) : $urandom_range(0, 1023);
               // mostly power-of-two cells, the tab rule is built around them
               cw = $urandom_range(0, 9) < 7 ? 1 << $urandom_range(0, 6) : $urandom_range(0, 64);
               ch = $urandom_range(0, 9) < 7 ? 1 << $urandom_range(0, 7) : $urandom_range(0, 128);
            end
         endcase
         write_reg(REG_AREA_WIDTH, aw);
         write_reg(REG_AREA_HEIGHT, ah);
         write_reg(REG_PAD_LEFT, pl);
         write_reg(REG_PAD_TOP, pt);
         write_reg(REG_CELL_WIDTH, cw);
         write_reg(REG_CELL_HEIGHT, ch);
         for (k = 0; k < PHASE_CHARS; k++) begin
            send_char(pick_char(), 1'b0, 1'b0, '0, '0);
            idle_after_send($urandom_range(0, 39) == 0);
         end
      end

      req_tvalid <= 1'b0;
      for (spin = 0; spin < 50000 && due_cmds.size() != 0; spin++) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (due_cmds.size() != 0) flag_mismatch("commands still due", due_cmds.size(), 0);
      if (mismatches == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

   initial begin : watchdog
      #5_000_000;
      $display("TEST FAILED");
      $finish;
   end

endmodule

FILE: text_console_cursor_control.f
hdl/tcc_pkg.sv
hdl/tcc_ctrl.sv
hdl/tcc_datapath.sv
hdl/text_console_cursor_control.sv
tb/tb.sv
